@@ src/bmbox_pkg.sv @@
package bmbox_pkg;

  localparam int DEF_MAX_ROW_PIXELS = 64;
  localparam int MAX_ROWS           = 64;
  localparam logic [15:0] DEF_PIXEL_SIZE = 16'd100;

  // columns up to 64 and rows up to 1024 fit these widths
  localparam int COL_W = 7;
  localparam int ROW_W = 11;

  localparam int CMDQ_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_ROW_END,
    CMD_GLYPH_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [COL_W-1:0]   first;
    logic [COL_W-1:0]   last;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               glyph_follows;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0] first;
    logic [COL_W-1:0] last;
    logic [ROW_W-1:0] top;
  } run_ent_t;

  typedef struct packed {
    logic [COL_W-1:0]   first;
    logic [COL_W-1:0]   last;
    logic [ROW_W-1:0]   top;
    logic [ROW_W-1:0]   bottom;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               last_box;
  } box_req_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SCAN,
    F_CLOSE,
    F_ROW,
    F_GLYPH
  } fr_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN_RD,
    B_RUN_CMP,
    B_EMIT_RD,
    B_EMIT_CHK,
    B_FLUSH
  } bk_state_t;

endpackage

@@ src/bmbox_ram.sv @@
module bmbox_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bmbox_front.sv @@
module bmbox_front #(
  parameter int MAX_ROW_PIXELS = bmbox_pkg::DEF_MAX_ROW_PIXELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_bitmap_byte,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic               in_row_end,
  input  logic               in_glyph_end,
  input  logic               q_ready,
  output logic               q_push,
  output bmbox_pkg::cmd_t    q_cmd
);

  localparam logic [bmbox_pkg::COL_W-1:0] COL_LIM = bmbox_pkg::COL_W'(MAX_ROW_PIXELS);
  localparam logic [bmbox_pkg::ROW_W-1:0] ROW_LIM = bmbox_pkg::ROW_W'(bmbox_pkg::MAX_ROWS);

  bmbox_pkg::fr_state_t st_r, st_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic rowend_r, rowend_nxt;
  logic glyend_r, glyend_nxt;
  logic in_glyph_r, in_glyph_nxt;
  logic signed [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [bmbox_pkg::COL_W-1:0] col_r, col_nxt, start_r, start_nxt;
  logic open_r, open_nxt;
  logic [bmbox_pkg::ROW_W-1:0] rows_r, rows_nxt;

  // scan up to and including the first pixel that closes a run
  logic [7:0] sc_rem;
  logic sc_open, sc_found;
  logic [bmbox_pkg::COL_W-1:0] sc_col, sc_start, sc_first, sc_last;

  always_comb begin
    sc_rem   = rem_r;
    sc_open  = open_r;
    sc_col   = col_r;
    sc_start = start_r;
    sc_found = 1'b0;
    sc_first = start_r;
    sc_last  = col_r;
    for (int k = 0; k < 8; k++) begin
      if (sc_rem[k] && !sc_found) begin
        sc_rem[k] = 1'b0;
        if (sc_col < COL_LIM) begin
          if (byte_r[3'(7 - k)] && !sc_open) begin
            sc_start = sc_col;
            sc_open  = 1'b1;
          end else if (!byte_r[3'(7 - k)] && sc_open) begin
            sc_found = 1'b1;
            sc_first = sc_start;
            sc_last  = sc_col;
            sc_open  = 1'b0;
          end
          sc_col = sc_col + 1'b1;
        end
      end
    end
  end

  always_comb begin
    st_nxt       = st_r;
    byte_nxt     = byte_r;
    rem_nxt      = rem_r;
    rowend_nxt   = rowend_r;
    glyend_nxt   = glyend_r;
    in_glyph_nxt = in_glyph_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    col_nxt      = col_r;
    start_nxt    = start_r;
    open_nxt     = open_r;
    rows_nxt     = rows_r;
    in_stall     = (st_r != bmbox_pkg::F_IDLE);
    q_push       = 1'b0;
    q_cmd.kind          = bmbox_pkg::CMD_RUN;
    q_cmd.first         = start_r;
    q_cmd.last          = col_r;
    q_cmd.origin_x      = ox_r;
    q_cmd.origin_y      = oy_r;
    q_cmd.glyph_follows = glyend_r;
    unique case (st_r)
      bmbox_pkg::F_IDLE: begin
        if (in_valid) begin
          byte_nxt   = in_bitmap_byte;
          rem_nxt    = 8'hFF;
          rowend_nxt = in_row_end;
          glyend_nxt = in_glyph_end;
          if (!in_glyph_r) begin
            ox_nxt       = in_origin_x;
            oy_nxt       = in_origin_y;
            in_glyph_nxt = 1'b1;
          end
          if (rows_r < ROW_LIM) begin
            st_nxt = bmbox_pkg::F_SCAN;
          end else if (in_glyph_end) begin
            st_nxt = bmbox_pkg::F_GLYPH;
          end
        end
      end
      bmbox_pkg::F_SCAN: begin
        if (!sc_found || q_ready) begin
          q_push      = sc_found;
          q_cmd.first = sc_first;
          q_cmd.last  = sc_last;
          rem_nxt     = sc_rem;
          col_nxt     = sc_col;
          open_nxt    = sc_open;
          start_nxt   = sc_start;
          if (sc_rem == 8'd0) begin
            st_nxt = (rowend_r || glyend_r) ? bmbox_pkg::F_CLOSE : bmbox_pkg::F_IDLE;
          end
        end
      end
      bmbox_pkg::F_CLOSE: begin
        if (!open_r) begin
          st_nxt = bmbox_pkg::F_ROW;
        end else if (q_ready) begin
          q_push   = 1'b1;
          open_nxt = 1'b0;
          st_nxt   = bmbox_pkg::F_ROW;
        end
      end
      bmbox_pkg::F_ROW: begin
        q_cmd.kind = bmbox_pkg::CMD_ROW_END;
        if (q_ready) begin
          q_push   = 1'b1;
          col_nxt  = '0;
          rows_nxt = rows_r + 1'b1;
          st_nxt   = glyend_r ? bmbox_pkg::F_GLYPH : bmbox_pkg::F_IDLE;
        end
      end
      bmbox_pkg::F_GLYPH: begin
        q_cmd.kind = bmbox_pkg::CMD_GLYPH_END;
        if (q_ready) begin
          q_push       = 1'b1;
          in_glyph_nxt = 1'b0;
          col_nxt      = '0;
          open_nxt     = 1'b0;
          start_nxt    = '0;
          rows_nxt     = '0;
          st_nxt       = bmbox_pkg::F_IDLE;
        end
      end
      default: st_nxt = bmbox_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= bmbox_pkg::F_IDLE;
      in_glyph_r <= 1'b0;
      col_r      <= '0;
      start_r    <= '0;
      open_r     <= 1'b0;
      rows_r     <= '0;
      rem_r      <= '0;
      rowend_r   <= 1'b0;
      glyend_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      in_glyph_r <= in_glyph_nxt;
      col_r      <= col_nxt;
      start_r    <= start_nxt;
      open_r     <= open_nxt;
      rows_r     <= rows_nxt;
      rem_r      <= rem_nxt;
      rowend_r   <= rowend_nxt;
      glyend_r   <= glyend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
  end

endmodule

@@ src/bmbox_cmdq.sv @@
module bmbox_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bmbox_pkg::cmd_t push_cmd,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output bmbox_pkg::cmd_t head
);

  localparam int AW = $clog2(bmbox_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(bmbox_pkg::CMDQ_DEPTH + 1);

  bmbox_pkg::cmd_t mem_r [bmbox_pkg::CMDQ_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign ready = (cnt_r < CW'(bmbox_pkg::CMDQ_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && ready) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop && valid) begin
      rp_nxt = rp_r + 1'b1;
    end
    if ((push && ready) && !(pop && valid)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && ready) && (pop && valid)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ready) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

@@ src/bmbox_back.sv @@
module bmbox_back #(
  parameter int MAX_ROW_PIXELS = bmbox_pkg::DEF_MAX_ROW_PIXELS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bmbox_pkg::cmd_t     q_cmd,
  output logic                q_pop,
  input  logic                calc_ready,
  output logic                calc_valid,
  output bmbox_pkg::box_req_t calc_req
);

  localparam int RUN_DEPTH = MAX_ROW_PIXELS / 2;
  localparam int AW = $clog2(RUN_DEPTH);
  localparam int CW = $clog2(RUN_DEPTH + 1);
  localparam int EW = $bits(bmbox_pkg::run_ent_t);

  bmbox_pkg::bk_state_t st_r, st_nxt;
  bmbox_pkg::cmd_t cmd_r, cmd_nxt;
  bmbox_pkg::box_req_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  logic sel_r, sel_nxt;
  logic [CW-1:0] ucount_r, ucount_nxt, ccount_r, ccount_nxt;
  logic [CW-1:0] j_r, j_nxt, e_r, e_nxt;
  logic [RUN_DEPTH-1:0] cont_r, cont_nxt;
  logic [bmbox_pkg::ROW_W-1:0] row_r, row_nxt;

  logic wr_en;
  bmbox_pkg::run_ent_t wr_ent, up_ent;
  logic [EW-1:0] rdata0, rdata1;
  logic [AW-1:0] raddr;

  // sel_r names the bank holding the row above; the other one collects this row
  bmbox_ram #(.WIDTH(EW), .DEPTH(RUN_DEPTH)) u_bank0 (
    .clk   (clk),
    .we    (wr_en && sel_r),
    .waddr (ccount_r[AW-1:0]),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (rdata0)
  );

  bmbox_ram #(.WIDTH(EW), .DEPTH(RUN_DEPTH)) u_bank1 (
    .clk   (clk),
    .we    (wr_en && !sel_r),
    .waddr (ccount_r[AW-1:0]),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (rdata1)
  );

  assign up_ent = sel_r ? rdata1 : rdata0;
  assign raddr  = (st_r == bmbox_pkg::B_RUN_RD || st_r == bmbox_pkg::B_RUN_CMP) ?
                  j_r[AW-1:0] : e_r[AW-1:0];

  always_comb begin
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    sel_nxt    = sel_r;
    ucount_nxt = ucount_r;
    ccount_nxt = ccount_r;
    j_nxt      = j_r;
    e_nxt      = e_r;
    cont_nxt   = cont_r;
    row_nxt    = row_r;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    wr_ent.first = cmd_r.first;
    wr_ent.last  = cmd_r.last;
    wr_ent.top   = row_r;
    calc_valid = 1'b0;
    calc_req   = pend_r;
    calc_req.last_box = 1'b0;
    unique case (st_r)
      bmbox_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          e_nxt   = '0;
          st_nxt  = (q_cmd.kind == bmbox_pkg::CMD_RUN) ? bmbox_pkg::B_RUN_RD :
                    bmbox_pkg::B_EMIT_RD;
        end
      end
      bmbox_pkg::B_RUN_RD: st_nxt = bmbox_pkg::B_RUN_CMP;
      bmbox_pkg::B_RUN_CMP: begin
        // upper runs are sorted and disjoint, so one forward walk finds the match
        if (j_r < ucount_r && up_ent.first < cmd_r.first) begin
          j_nxt  = j_r + 1'b1;
          st_nxt = bmbox_pkg::B_RUN_RD;
        end else begin
          if (j_r < ucount_r && up_ent.first == cmd_r.first && up_ent.last == cmd_r.last) begin
            wr_ent.top = up_ent.top;
            cont_nxt[j_r[AW-1:0]] = 1'b1;
            j_nxt = j_r + 1'b1;
          end
          if (ccount_r < CW'(RUN_DEPTH)) begin
            wr_en      = 1'b1;
            ccount_nxt = ccount_r + 1'b1;
          end
          st_nxt = bmbox_pkg::B_IDLE;
        end
      end
      bmbox_pkg::B_EMIT_RD: st_nxt = bmbox_pkg::B_EMIT_CHK;
      bmbox_pkg::B_EMIT_CHK: begin
        if (e_r < ucount_r) begin
          if (cont_r[e_r[AW-1:0]]) begin
            e_nxt  = e_r + 1'b1;
            st_nxt = bmbox_pkg::B_EMIT_RD;
          end else if (!pend_v_r || calc_ready) begin
            // hold one box back so the last one of the beat can be flagged
            calc_valid        = pend_v_r;
            pend_nxt.first    = up_ent.first;
            pend_nxt.last     = up_ent.last;
            pend_nxt.top      = up_ent.top;
            pend_nxt.bottom   = row_r - 1'b1;
            pend_nxt.origin_x = cmd_r.origin_x;
            pend_nxt.origin_y = cmd_r.origin_y;
            pend_nxt.last_box = 1'b0;
            pend_v_nxt        = 1'b1;
            e_nxt             = e_r + 1'b1;
            st_nxt            = bmbox_pkg::B_EMIT_RD;
          end
        end else begin
          cont_nxt   = '0;
          j_nxt      = '0;
          ccount_nxt = '0;
          if (cmd_r.kind == bmbox_pkg::CMD_ROW_END) begin
            sel_nxt    = !sel_r;
            ucount_nxt = ccount_r;
            row_nxt    = row_r + 1'b1;
            st_nxt     = cmd_r.glyph_follows ? bmbox_pkg::B_IDLE : bmbox_pkg::B_FLUSH;
          end else begin
            ucount_nxt = '0;
            row_nxt    = '0;
            st_nxt     = bmbox_pkg::B_FLUSH;
          end
        end
      end
      bmbox_pkg::B_FLUSH: begin
        calc_req.last_box = 1'b1;
        if (!pend_v_r) begin
          st_nxt = bmbox_pkg::B_IDLE;
        end else if (calc_ready) begin
          calc_valid = 1'b1;
          pend_v_nxt = 1'b0;
          st_nxt     = bmbox_pkg::B_IDLE;
        end
      end
      default: st_nxt = bmbox_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= bmbox_pkg::B_IDLE;
      pend_v_r <= 1'b0;
      sel_r    <= 1'b0;
      ucount_r <= '0;
      ccount_r <= '0;
      j_r      <= '0;
      e_r      <= '0;
      cont_r   <= '0;
      row_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      pend_v_r <= pend_v_nxt;
      sel_r    <= sel_nxt;
      ucount_r <= ucount_nxt;
      ccount_r <= ccount_nxt;
      j_r      <= j_nxt;
      e_r      <= e_nxt;
      cont_r   <= cont_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
  end

`ifndef SYNTHESIS
  a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
    ucount_r <= CW'(RUN_DEPTH) && ccount_r <= CW'(RUN_DEPTH))
    else $error("run count beyond run store depth");

  a_send_ready: assert property (@(posedge clk) disable iff (!rst_n)
    calc_valid |-> calc_ready)
    else $error("box sent while box unit is full");

  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == bmbox_pkg::B_FLUSH && calc_ready) |=> !pend_v_r)
    else $error("held box not released at end of beat");

  a_glyph_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == bmbox_pkg::B_EMIT_CHK && e_r >= ucount_r &&
     cmd_r.kind == bmbox_pkg::CMD_GLYPH_END) |=> (ucount_r == '0 && row_r == '0))
    else $error("glyph end left run state behind");
`endif

endmodule

@@ src/bmbox_calc.sv @@
module bmbox_calc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         pixel_size,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmbox_pkg::box_req_t in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [21:0]         out_box_width,
  output logic [21:0]         out_box_height,
  output logic signed [32:0]  out_center_x,
  output logic signed [32:0]  out_center_y,
  output logic                out_last_box
);

  logic v1_r, v2_r, adv1, adv2;
  logic [21:0] w_r;
  logic [26:0] h_r;
  logic signed [34:0] xl_r, yl_r;
  logic last1_r;

  logic signed [17:0] xs, ys;
  logic signed [16:0] ps;
  logic [bmbox_pkg::COL_W-1:0] wc;
  logic [bmbox_pkg::ROW_W-1:0] hc;
  logic [22:0] w_mul;
  logic [26:0] h_mul;
  logic signed [34:0] xl_mul, yl_mul, cx_sum, cy_sum;

  assign adv2     = !v2_r || !out_stall;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  assign ps = $signed({1'b0, pixel_size});
  assign xs = $signed({{2{in_req.origin_x[15]}}, in_req.origin_x} +
                      {{(18 - bmbox_pkg::COL_W){1'b0}}, in_req.first});
  assign ys = $signed({{2{in_req.origin_y[15]}}, in_req.origin_y} -
                      {{(18 - bmbox_pkg::ROW_W){1'b0}}, in_req.bottom} - 18'd1);
  assign wc = in_req.last - in_req.first;
  assign hc = in_req.bottom - in_req.top + 1'b1;
  assign w_mul  = 23'(wc) * 23'(pixel_size);
  assign h_mul  = 27'(hc) * 27'(pixel_size);
  assign xl_mul = xs * ps;
  assign yl_mul = ys * ps;

  assign cx_sum = xl_r + $signed({14'd0, w_r[21:1]});
  assign cy_sum = yl_r + $signed({9'd0, h_r[26:1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      w_r     <= w_mul[21:0];
      h_r     <= h_mul;
      xl_r    <= xl_mul;
      yl_r    <= yl_mul;
      last1_r <= in_req.last_box;
    end
    if (adv2) begin
      out_box_width  <= w_r;
      out_box_height <= h_r[21:0];
      out_center_x   <= cx_sum[32:0];
      out_center_y   <= cy_sum[32:0];
      out_last_box   <= last1_r;
    end
  end

  assign out_valid = v2_r;

endmodule

@@ src/bitmap_runs_to_merged_boxes.sv @@
// channel  | handshake          | payload
// in       | in_valid/in_stall  | bitmap_byte, origin_x, origin_y, row_end, glyph_end
// out      | out_valid/out_stall| box_width, box_height, center_x, center_y, last_box
// cfg      | cfg_valid/cfg_ready| pixel_size (always ready)
//
// a byte is taken only while the scanner is idle, then scanned one run at a time;
// a row end walks the runs of the row above one by one through the single
// read port of the run banks, and each box then passes through the multiply
// and add stages. reset is synchronous; pixel_size resets to 100.
// a command queue sits between scanner and run merger, so either may stall alone.
module bitmap_runs_to_merged_boxes #(
  parameter int MAX_ROW_PIXELS = bmbox_pkg::DEF_MAX_ROW_PIXELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_bitmap_byte,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic               in_row_end,
  input  logic               in_glyph_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [21:0]        out_box_width,
  output logic [21:0]        out_box_height,
  output logic signed [32:0] out_center_x,
  output logic signed [32:0] out_center_y,
  output logic               out_last_box,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_pixel_size
);

  logic [15:0] pixel_size_r;
  logic q_push, q_ready, q_pop, q_valid;
  bmbox_pkg::cmd_t q_in, q_head;
  logic calc_valid, calc_ready;
  bmbox_pkg::box_req_t calc_req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_size_r <= bmbox_pkg::DEF_PIXEL_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      pixel_size_r <= cfg_pixel_size;
    end
  end

  bmbox_front #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_bitmap_byte (in_bitmap_byte),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_row_end     (in_row_end),
    .in_glyph_end   (in_glyph_end),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_cmd          (q_in)
  );

  bmbox_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  bmbox_back #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .calc_ready (calc_ready),
    .calc_valid (calc_valid),
    .calc_req   (calc_req)
  );

  bmbox_calc u_calc (
    .clk            (clk),
    .rst_n          (rst_n),
    .pixel_size     (pixel_size_r),
    .in_valid       (calc_valid),
    .in_ready       (calc_ready),
    .in_req         (calc_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_last_box   (out_last_box)
  );

endmodule

@@ tb/bitmap_runs_to_merged_boxes_test.sv @@
`timescale 1ns / 1ps

module bitmap_runs_to_merged_boxes_test;

  localparam int ROW_PIX    = 64;
  localparam int ROW_LIMIT  = 64;
  localparam int RUN_SLOTS  = ROW_PIX / 2;
  localparam int SETTLE     = 400;
  localparam int CYCLE_CAP  = 1500000;
  localparam int RAND_BYTES = 120;

  typedef struct packed {
    logic [6:0]  first;
    logic [6:0]  last;
    logic [10:0] top;
  } pixel_run_t;

  typedef struct packed {
    logic [21:0]        width;
    logic [21:0]        height;
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic               last_box;
  } box_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_bitmap_byte;
  logic signed [15:0] in_origin_x;
  logic signed [15:0] in_origin_y;
  logic               in_row_end;
  logic               in_glyph_end;
  logic               out_valid;
  logic               out_stall;
  logic [21:0]        out_box_width;
  logic [21:0]        out_box_height;
  logic signed [32:0] out_center_x;
  logic signed [32:0] out_center_y;
  logic               out_last_box;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_pixel_size;

  bitmap_runs_to_merged_boxes dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_bitmap_byte(in_bitmap_byte), .in_origin_x(in_origin_x),
    .in_origin_y(in_origin_y), .in_row_end(in_row_end), .in_glyph_end(in_glyph_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_box_width(out_box_width), .out_box_height(out_box_height),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_last_box(out_last_box),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pixel_size(cfg_pixel_size)
  );

  // glyph tracking state
  pixel_run_t  upper_runs [RUN_SLOTS];
  pixel_run_t  cur_runs [RUN_SLOTS];
  int          upper_cnt;
  int          cur_cnt;
  logic [31:0] upper_merged;
  bit          run_open;
  int          run_start;
  int          column;
  int          row_idx;
  int          org_x;
  int          org_y;
  bit          in_glyph;
  logic [15:0] pix_size;

  box_t        box_q[$];
  int          errors;
  int          cycles;
  int          bytes_sent;
  bit          tx_idle;
  bit          rx_idle;
  int          hold_req;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_glyph();
    upper_cnt = 0;
    cur_cnt = 0;
    upper_merged = '0;
    run_open = 0;
    run_start = 0;
    column = 0;
    row_idx = 0;
    org_x = 0;
    org_y = 0;
    in_glyph = 0;
  endfunction

  function automatic void push_box(pixel_run_t r, int bottom);
    longint p, xl, w, yl, h;
    box_t b;
    p = longint'(pix_size);
    xl = (longint'(org_x) + longint'(r.first)) * p;
    w = (longint'(r.last) - longint'(r.first)) * p;
    yl = (longint'(org_y) - longint'(bottom) - 1) * p;
    h = (longint'(bottom) - longint'(r.top) + 1) * p;
    b.width = w[21:0];
    b.height = h[21:0];
    b.cx = 33'(xl + w / 2);
    b.cy = 33'(yl + h / 2);
    b.last_box = 1'b0;
    box_q.push_back(b);
  endfunction

  function automatic void close_run(int end_col);
    if (cur_cnt < RUN_SLOTS) begin
      cur_runs[cur_cnt].first = 7'(run_start);
      cur_runs[cur_cnt].last = 7'(end_col);
      cur_runs[cur_cnt].top = 11'(row_idx);
      cur_cnt++;
    end
    run_open = 0;
  endfunction

  function automatic void flush_upper(logic [31:0] skip);
    for (int i = 0; i < upper_cnt; i++)
      if (!skip[i]) push_box(upper_runs[i], row_idx - 1);
  endfunction

  function automatic void end_row();
    if (run_open) close_run(column);
    for (int i = 0; i < cur_cnt; i++) begin
      for (int j = 0; j < upper_cnt; j++) begin
        if (!upper_merged[j] && upper_runs[j].first == cur_runs[i].first &&
            upper_runs[j].last == cur_runs[i].last) begin
          cur_runs[i].top = upper_runs[j].top;
          upper_merged[j] = 1'b1;
          break;
        end
      end
    end
    flush_upper(upper_merged);
    upper_runs = cur_runs;
    upper_cnt = cur_cnt;
    cur_cnt = 0;
    upper_merged = '0;
    column = 0;
    row_idx++;
  endfunction

  function automatic void track_byte(logic [7:0] bits, logic signed [15:0] ox,
                                     logic signed [15:0] oy, bit re, bit ge);
    int prior_cnt;
    prior_cnt = box_q.size();
    if (!in_glyph) begin
      org_x = int'(ox);
      org_y = int'(oy);
      in_glyph = 1;
    end
    if (row_idx < ROW_LIMIT) begin
      for (int k = 7; k >= 0; k--) begin
        if (column < ROW_PIX) begin
          if (bits[k] && !run_open) begin
            run_start = column;
            run_open = 1;
          end else if (!bits[k] && run_open) begin
            close_run(column);
          end
          column++;
        end
      end
      if (re || ge) end_row();
    end
    if (ge) begin
      flush_upper('0);
      clear_glyph();
    end
    if (box_q.size() > prior_cnt) box_q[box_q.size() - 1].last_box = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] bits, logic signed [15:0] ox,
                           logic signed [15:0] oy, bit re, bit ge);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bitmap_byte = bits;
    in_origin_x = ox;
    in_origin_y = oy;
    in_row_end = re;
    in_glyph_end = ge;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    track_byte(bits, ox, oy, re, ge);
    bytes_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (box_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_pixel_size(logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_pixel_size = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pix_size = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // box sink: random stall per beat, plus an optional long hold-off
  initial begin
    int w;
    box_t exp_box;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      w = rx_idle ? $urandom_range(0, 17) : 0;
      if (hold_req > 0) begin
        w = hold_req;
        hold_req = 0;
      end
      if (w > 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (box_q.size() == 0) begin
        $error("box with no expectation: width %0d height %0d",
               out_box_width, out_box_height);
        errors++;
      end else begin
        exp_box = box_q.pop_front();
        if (out_box_width !== exp_box.width) begin
          $error("box_width expected %0d got %0d", exp_box.width, out_box_width);
          errors++;
        end
        if (out_box_height !== exp_box.height) begin
          $error("box_height expected %0d got %0d", exp_box.height, out_box_height);
          errors++;
        end
        if (out_center_x !== exp_box.cx) begin
          $error("center_x expected %0d got %0d", exp_box.cx, out_center_x);
          errors++;
        end
        if (out_center_y !== exp_box.cy) begin
          $error("center_y expected %0d got %0d", exp_box.cy, out_center_y);
          errors++;
        end
        if (out_last_box !== exp_box.last_box) begin
          $error("last_box expected %0d got %0d", exp_box.last_box, out_last_box);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  task automatic test_shapes();
    // single full byte at extreme origins, then an empty glyph
    send_byte(8'hFF, 16'sh7FFF, -16'sh8000, 1, 1);
    send_byte(8'h00, -16'sh8000, 16'sh7FFF, 0, 1);
    // two stacked columns merge, third row differs
    send_byte(8'h81, 16'sd3, 16'sd10, 1, 0);
    send_byte(8'h81, 16'sd0, 16'sd0, 1, 0);
    send_byte(8'hA5, 16'sd0, 16'sd0, 0, 1);
    // run crossing a byte boundary, glyph closed mid-row
    send_byte(8'h0F, -16'sd5, -16'sd7, 0, 0);
    send_byte(8'hF0, 16'sd0, 16'sd0, 0, 1);
  endtask

  task automatic test_wide_row();
    for (int i = 0; i < 9; i++) send_byte(8'hFF, 16'sd1, 16'sd2, i == 8, 0);
    send_byte(8'h55, 16'sd0, 16'sd0, 1, 1);
  endtask

  task automatic test_row_limit();
    for (int i = 0; i < ROW_LIMIT + 2; i++) send_byte(8'h80, 16'sd4, 16'sd4, 1, 0);
    send_byte(8'hC3, 16'sd0, 16'sd0, 1, 1);
  endtask

  task automatic test_zero_pixel();
    write_pixel_size(16'd0);
    send_byte(8'h3C, 16'sd9, -16'sd9, 1, 0);
    send_byte(8'h3C, 16'sd0, 16'sd0, 0, 1);
  endtask

  task automatic test_size_extremes();
    write_pixel_size(16'hFFFF);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, 16'sh7FFF, -16'sh8000, 0, 0);
    send_byte(8'h00, 16'sd0, 16'sd0, 1, 1);
    write_pixel_size(16'd1);
    send_byte(8'h99, -16'sh8000, -16'sh8000, 1, 1);
  endtask

  // mostly well-formed glyphs; rows often repeat to exercise merging
  task automatic random_glyph();
    int nbytes, nrows;
    logic [7:0] row_bits [10];
    logic signed [15:0] ox, oy;
    bit ge;
    nbytes = ($urandom_range(0, 9) == 0) ? 9 : $urandom_range(1, 3);
    nrows = $urandom_range(1, 7);
    ox = 16'($urandom);
    oy = 16'($urandom);
    for (int b = 0; b < nbytes; b++) row_bits[b] = 8'($urandom);
    for (int r = 0; r < nrows; r++) begin
      if ($urandom_range(0, 2) == 0)
        for (int b = 0; b < nbytes; b++) row_bits[b] = 8'($urandom);
      for (int b = 0; b < nbytes; b++) begin
        ge = (r == nrows - 1) && (b == nbytes - 1);
        if ($urandom_range(0, 15) == 0)
          send_byte(8'($urandom), 16'($urandom), 16'($urandom),
                    1'($urandom_range(0, 1)), ge);
        else
          send_byte(row_bits[b], (r == 0 && b == 0) ? ox : 16'($urandom), 16'($urandom),
                    (b == nbytes - 1) && !(ge && $urandom_range(0, 3) == 0), ge);
      end
    end
  endtask

  task automatic test_random();
    int start;
    logic [15:0] sizes [4];
    sizes[0] = 16'($urandom_range(2, 300));
    sizes[1] = 16'hFFFF;
    sizes[2] = 16'($urandom);
    sizes[3] = 16'd100;
    start = bytes_sent;
    for (int phase = 0; phase < 4; phase++) begin
      write_pixel_size(sizes[phase]);
      tx_idle = (phase != 2);
      rx_idle = (phase != 1);
      while (bytes_sent - start < (phase + 1) * RAND_BYTES / 4) random_glyph();
    end
    tx_idle = 1;
    rx_idle = 1;
  endtask

  task automatic test_backpressure();
    drain();
    tx_idle = 0;
    hold_req = 600;
    for (int r = 0; r < 24; r++) begin
      send_byte((r % 3 == 0) ? 8'hA5 : 8'h5A, 16'sd1, 16'sd1, 0, 0);
      send_byte(8'($urandom), 16'sd1, 16'sd1, 1, r == 23);
    end
    tx_idle = 1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_bitmap_byte = '0;
    in_origin_x = '0;
    in_origin_y = '0;
    in_row_end = 1'b0;
    in_glyph_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_pixel_size = '0;
    errors = 0;
    cycles = 0;
    bytes_sent = 0;
    tx_idle = 1;
    rx_idle = 1;
    hold_req = 0;
    pix_size = 16'd100;
    clear_glyph();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_shapes();
    test_wide_row();
    test_row_limit();
    test_zero_pixel();
    test_size_extremes();
    test_random();
    test_backpressure();
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/bmbox_pkg.sv
src/bmbox_ram.sv
src/bmbox_front.sv
src/bmbox_cmdq.sv
src/bmbox_back.sv
src/bmbox_calc.sv
src/bitmap_runs_to_merged_boxes.sv
tb/bitmap_runs_to_merged_boxes_test.sv
